// ===== rtl/core/serial_frame_receiver_top_macros.svh =====
// Assertion helpers used by the receiver parser.
`ifndef SERIAL_FRAME_RECEIVER_TOP_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SFR_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sfr: implication check failed");

// Next-cycle implication, checked outside reset.
`define SFR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sfr: next-cycle check failed");

`endif

// ===== rtl/core/sfr_pkg.sv =====
`default_nettype none
package sfr_pkg;

    // Parser phases
    localparam logic [2:0] PH_SYNC1 = 3'd0;
    localparam logic [2:0] PH_SYNC2 = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_ID    = 3'd3;
    localparam logic [2:0] PH_BODY  = 3'd4;
    localparam logic [2:0] PH_CHECK = 3'd5;

    // Event kinds
    localparam logic [1:0] EV_GOOD    = 2'd0;
    localparam logic [1:0] EV_BADSUM  = 2'd1;
    localparam logic [1:0] EV_TOOLONG = 2'd2;

    // Register indexes on the configuration port
    localparam logic [7:0] REG_SYNC_FIRST   = 8'd0;
    localparam logic [7:0] REG_SYNC_SECOND  = 8'd1;
    localparam logic [7:0] REG_PAYLOAD_LIM  = 8'd2;
    localparam logic [7:0] REG_POSITION_ID  = 8'd3;
    localparam logic [7:0] REG_ACK_ID       = 8'd4;

    // Reset values of the registers
    localparam logic [7:0] SYNC_FIRST_RST  = 8'd36;
    localparam logic [7:0] SYNC_SECOND_RST = 8'd64;
    localparam logic [7:0] PAYLOAD_LIM_RST = 8'd64;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] payload_limit;
        logic [7:0] position_frame_id;
        logic [7:0] ack_frame_id;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [7:0]  frame_id;
        logic [7:0]  payload_length;
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic        is_position;
        logic        is_ack;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/sfr_cfg_regs.sv =====
`default_nettype none
module sfr_cfg_regs (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_index,
    input  wire logic [7:0]   cfg_data,
    output sfr_pkg::cfg_t     cfg
);
    import sfr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Always take a write; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_SYNC_FIRST:  cfg_next.sync_first        = cfg_data;
                REG_SYNC_SECOND: cfg_next.sync_second       = cfg_data;
                REG_PAYLOAD_LIM: cfg_next.payload_limit     = cfg_data;
                REG_POSITION_ID: cfg_next.position_frame_id = cfg_data;
                REG_ACK_ID:      cfg_next.ack_frame_id      = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first        <= SYNC_FIRST_RST;
            cfg_reg.sync_second       <= SYNC_SECOND_RST;
            cfg_reg.payload_limit     <= PAYLOAD_LIM_RST;
            cfg_reg.position_frame_id <= 8'd0;
            cfg_reg.ack_frame_id      <= 8'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== rtl/core/sfr_parser.sv =====
`default_nettype none
module sfr_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire sfr_pkg::cfg_t cfg,
    input  wire logic        out_free,
    output logic             res_valid,
    output sfr_pkg::result_t res
);
    import sfr_pkg::*;

    // Input word register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;

    // Frame state
    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       length_reg, length_next;
    logic [7:0]       id_reg, id_next;
    logic [7:0]       count_reg, count_next;
    logic [7:0]       sum_reg, sum_next;
    logic [3:0][7:0]  head_reg, head_next;

    logic       advance;
    logic       emit;
    logic [1:0] kind;
    logic       with_words;
    logic [7:0] b;

    // Work on the held word once the result slot can take its outcome
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || advance;
    assign b        = in_byte_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_ready) begin
            in_valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            in_byte_reg <= in_byte;
        end
    end

    // Per-word frame state update
    always_comb begin
        phase_next  = phase_reg;
        length_next = length_reg;
        id_next     = id_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        head_next   = head_reg;
        emit        = 1'b0;
        kind        = EV_GOOD;
        with_words  = 1'b0;
        if (advance) begin
            unique case (phase_reg)
                PH_SYNC2: begin
                    phase_next = (b == cfg.sync_second) ? PH_LEN : PH_SYNC1;
                end
                PH_LEN: begin
                    length_next = b;
                    phase_next  = PH_ID;
                end
                PH_ID: begin
                    id_next  = b;
                    sum_next = b;
                    if (length_reg == 8'd0) begin
                        phase_next = PH_CHECK;
                    end else if (length_reg < cfg.payload_limit) begin
                        phase_next = PH_BODY;
                    end else begin
                        phase_next = PH_SYNC1;
                        emit       = 1'b1;
                        kind       = EV_TOOLONG;
                    end
                end
                PH_BODY: begin
                    if (count_reg < 8'd4) begin
                        head_next[count_reg[1:0]] = b;
                    end
                    if (count_reg != 8'hFF) begin
                        count_next = count_reg + 8'd1;
                    end
                    sum_next = sum_reg + b;
                    if (count_next >= length_reg) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    phase_next = PH_SYNC1;
                    emit       = 1'b1;
                    with_words = 1'b1;
                    kind       = (sum_reg == b) ? EV_GOOD : EV_BADSUM;
                end
                default: begin
                    // hunt for the first sync byte; unused codes land here too
                    phase_next = PH_SYNC1;
                    if (b == cfg.sync_first) begin
                        phase_next = PH_SYNC2;
                        count_next = 8'd0;
                        head_next  = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SYNC1;
            length_reg <= 8'd0;
            id_reg     <= 8'd0;
            count_reg  <= 8'd0;
            sum_reg    <= 8'd0;
            head_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            id_reg     <= id_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            head_reg   <= head_next;
        end
    end

    // Build the result from the updated identifier and length
    always_comb begin
        res.event_kind     = kind;
        res.frame_id       = id_next;
        res.payload_length = length_next;
        res.first_word     = with_words ? {head_reg[0], head_reg[1]} : 16'd0;
        res.second_word    = with_words ? {head_reg[2], head_reg[3]} : 16'd0;
        res.is_position    = (kind == EV_GOOD) && (id_next == cfg.position_frame_id);
        res.is_ack         = (kind == EV_GOOD) && (id_next == cfg.ack_frame_id);
    end

    assign res_valid = emit;

    // Summary terms for the checks below
    logic flags_any;
    logic words_any;
    assign flags_any = res.is_position || res.is_ack;
    assign words_any = (res.first_word != 16'd0) || (res.second_word != 16'd0);

    `include "serial_frame_receiver_top_macros.svh"

    `SFR_ASSERT_IMPLY(a_flags_only_good, aclk, aresetn, res_valid && (res.event_kind != EV_GOOD), !flags_any)
    `SFR_ASSERT_IMPLY(a_toolong_no_words, aclk, aresetn, res_valid && (res.event_kind == EV_TOOLONG), !words_any)
    `SFR_ASSERT_NEXT(a_hunt_after_result, aclk, aresetn, res_valid, phase_reg == PH_SYNC1)
    `SFR_ASSERT_IMPLY(a_result_needs_slot, aclk, aresetn, res_valid, out_free && in_valid_reg)

endmodule
`default_nettype wire

// ===== rtl/core/sfr_out_stage.sv =====
`default_nettype none
module sfr_out_stage (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         res_valid,
    input  wire sfr_pkg::result_t res,
    output logic              out_free,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [47:0]       m_tdata,
    output logic [3:0]        m_tuser
);
    import sfr_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;

    // The slot frees up as soon as the held word is taken
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_valid) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    // Pack the result word
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.second_word, out_reg.first_word,
                       out_reg.payload_length, out_reg.frame_id};
    assign m_tuser  = {out_reg.is_ack, out_reg.is_position, out_reg.event_kind};

endmodule
`default_nettype wire

// ===== rtl/core/serial_frame_receiver_top.sv =====
// Channel  | Direction | Contents
// s_       | in        | tdata[7:0] rx_byte
// m_       | out       | tdata: frame_id, payload_length, first_word, second_word
//          |           | tuser: event_kind, is_position, is_ack
// cfg_     | in        | index 0..4 selects register, data is the 8-bit value
//
// One received byte per cycle while no result is held back by m_tready: an input
// register feeds the frame state update, whose outcome lands in a single output register.
// A result word is produced on the checksum byte or on an oversize length.
// Reset is synchronous on aresetn low; state and config registers return to their defaults.
// While m_tready is low with a result held, any byte in the input register waits
// there, whether or not it produces a result; s_tready drops only then.
`default_nettype none
module serial_frame_receiver_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [7:0] frame_id, [15:8] payload_length,
                                        // [31:16] first_word, [47:32] second_word
    output logic [3:0]       m_tuser,   // [1:0] event_kind, [2] is_position, [3] is_ack
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import sfr_pkg::*;

    cfg_t    cfg;
    result_t res;
    logic    res_valid;
    logic    out_free;

    sfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .cfg       (cfg),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    sfr_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire
